>>> rtl/x86_logic_shift_alu_defines.svh
// ----------------------------------------------------------------------------
// x86_logic_shift_alu_defines.svh
// Assertion macros shared by the logic and shift ALU.
// ----------------------------------------------------------------------------
`ifndef X86_LOGIC_SHIFT_ALU_DEFINES_SVH
`define X86_LOGIC_SHIFT_ALU_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Types, opcodes and helpers shared by the logic and shift ALU.
// ----------------------------------------------------------------------------
package lsa_pkg;

   // instruction codes
   localparam logic [3:0] CMD_AND   = 4'd0;
   localparam logic [3:0] CMD_OR    = 4'd1;
   localparam logic [3:0] CMD_XOR   = 4'd2;
   localparam logic [3:0] CMD_TEST  = 4'd3;
   localparam logic [3:0] CMD_NOT   = 4'd4;
   localparam logic [3:0] CMD_SAR   = 4'd5;
   localparam logic [3:0] CMD_SHL   = 4'd6;
   localparam logic [3:0] CMD_SHR   = 4'd7;
   localparam logic [3:0] CMD_ROL   = 4'd8;
   localparam logic [3:0] CMD_SETCC = 4'd9;

   // operand size codes, anything else is doubleword
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   // condition groups, upper three bits of the condition code
   localparam logic [2:0] COND_O  = 3'd0;
   localparam logic [2:0] COND_B  = 3'd1;
   localparam logic [2:0] COND_E  = 3'd2;
   localparam logic [2:0] COND_BE = 3'd3;
   localparam logic [2:0] COND_S  = 3'd4;
   localparam logic [2:0] COND_P  = 3'd5;
   localparam logic [2:0] COND_L  = 3'd6;
   localparam logic [2:0] COND_LE = 3'd7;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [1:0]  size_code;
      logic [31:0] dest_value;
      logic [31:0] src_value;
      logic [3:0]  cond_code;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        write_back;
      logic        carry_flag;
      logic        overflow_flag;
      logic        zero_flag;
      logic        sign_flag;
      logic        unsupported;
   } rsp_type;

   typedef struct packed {
      logic sf;
      logic zf;
      logic of;
      logic cf;
   } flags_type;

   // mask of the operand width
   function automatic logic [31:0] width_mask(input logic [1:0] size_code);
      logic [31:0] m;
      unique case (size_code)
         SIZE_BYTE: m = 32'h0000_00ff;
         SIZE_WORD: m = 32'h0000_ffff;
         default:   m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   // top bit of the operand width
   function automatic logic sign_bit(input logic [31:0] value,
                                     input logic [1:0]  size_code);
      logic s;
      unique case (size_code)
         SIZE_BYTE: s = value[7];
         SIZE_WORD: s = value[15];
         default:   s = value[31];
      endcase
      return s;
   endfunction

endpackage

>>> rtl/x86_logic_shift_alu.sv
// ----------------------------------------------------------------------------
// x86_logic_shift_alu
// x86 logic, shift and setcc ALU with kept CF/OF/ZF/SF flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction per transaction (cmd, size, operands,
//   condition code); rsp_* returns the masked result, write-back enable,
//   the flags after the instruction and the unsupported marker.
//   Both channels are valid/ready; a transaction moves when both are high.
// Pipeline and throughput:
//   an accepted request passes through the input register, then execute
//   logic into the response register, which drives rsp_valid. One
//   transaction per cycle is sustained while rsp_ready stays high; the
//   flag register is updated as each instruction moves into the response
//   register, so a setcc sees the flags just ahead of it.
// Stall:
//   while rsp_ready is low the response holds and the input register
//   still fills; req_ready drops only when both registers are full.
// Reset:
//   synchronous reset empties both registers and clears all four flags.
// ----------------------------------------------------------------------------
`include "x86_logic_shift_alu_defines.svh"

module x86_logic_shift_alu import lsa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_req_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_rsp_ff;
   flags_type flags_ff;
   flags_type flags_in;
   rsp_type   exec_rsp;
   logic      out_free;
   logic      advance;
   logic      req_take;

   // handshake control
   assign out_free  = ~out_valid_ff | rsp_ready;
   assign advance   = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   lsa_exec u_exec (
      .req       (in_req_ff),
      .flags_cur (flags_ff),
      .rsp       (exec_rsp),
      .flags_nxt (flags_in)
   );

   // valid bits and kept flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         out_rsp_ff <= exec_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   // checks
   `LSA_ASSERT_SAME(a_flags_match, clock, reset, out_valid_ff,
      (out_rsp_ff.carry_flag == flags_ff.cf) && (out_rsp_ff.overflow_flag == flags_ff.of)
      && (out_rsp_ff.zero_flag == flags_ff.zf) && (out_rsp_ff.sign_flag == flags_ff.sf),
      "response flags differ from kept flags")
   `LSA_ASSERT_SAME(a_unsup_quiet, clock, reset, out_valid_ff && out_rsp_ff.unsupported,
      (out_rsp_ff.result_value == '0) && !out_rsp_ff.write_back,
      "unsupported response carries a result")
   `LSA_ASSERT_NEXT(a_take_fills, clock, reset, req_take, in_valid_ff,
      "accepted request not held in input register")
   `LSA_ASSERT_SAME(a_reset_flags, clock, reset, $past(reset),
      (flags_ff == '0) && !in_valid_ff && !out_valid_ff,
      "state not cleared by reset")

endmodule

>>> rtl/lsa_shift.sv
// ----------------------------------------------------------------------------
// lsa_shift
// Barrel shifter for sar, shl, shr and rol at byte, word or doubleword width.
// ----------------------------------------------------------------------------
module lsa_shift import lsa_pkg::*; (
   input  logic [3:0]  cmd,
   input  logic [1:0]  size_code,
   input  logic [31:0] value,
   input  logic [4:0]  count,
   output logic [31:0] result
);

   logic [31:0]        mask;
   logic signed [31:0] sext;
   logic [31:0]        sar_val;
   logic [31:0]        rep;
   logic [63:0]        rot_wide;

   assign mask = width_mask(size_code);

   // sign-extend the operand from its width to 32 bits
   always_comb begin
      unique case (size_code)
         SIZE_BYTE: sext = {{24{value[7]}}, value[7:0]};
         SIZE_WORD: sext = {{16{value[15]}}, value[15:0]};
         default:   sext = value;
      endcase
   end

   assign sar_val = sext >>> count;

   // replicate the operand so a 32-bit rotate is a rotate modulo the width
   always_comb begin
      unique case (size_code)
         SIZE_BYTE: rep = {4{value[7:0]}};
         SIZE_WORD: rep = {2{value[15:0]}};
         default:   rep = value;
      endcase
   end

   assign rot_wide = {rep, rep} << count;

   // select by operation
   always_comb begin
      case (cmd)
         CMD_SAR: result = sar_val & mask;
         CMD_SHL: result = (value << count) & mask;
         CMD_SHR: result = (value & mask) >> count;
         CMD_ROL: result = rot_wide[63:32] & mask;
         default: result = '0;
      endcase
   end

endmodule

>>> rtl/lsa_exec.sv
// ----------------------------------------------------------------------------
// lsa_exec
// Execute logic: result, write-back, setcc and next flag values.
// ----------------------------------------------------------------------------
module lsa_exec import lsa_pkg::*; (
   input  req_type   req,
   input  flags_type flags_cur,
   output rsp_type   rsp,
   output flags_type flags_nxt
);

   logic [31:0] mask;
   logic [31:0] dest;
   logic [31:0] shift_res;
   logic [4:0]  count;
   logic [31:0] res;
   logic        wb;
   logic        unsup;

   // evaluate an x86 condition code from the kept flags
   function automatic logic eval_cond(input logic [3:0] cc, input flags_type f);
      logic v;
      unique case (cc[3:1])
         COND_O:  v = f.of;
         COND_B:  v = f.cf;
         COND_E:  v = f.zf;
         COND_BE: v = f.cf | f.zf;
         COND_S:  v = f.sf;
         COND_L:  v = f.sf ^ f.of;
         COND_LE: v = f.zf | (f.sf ^ f.of);
         default: v = 1'b0;
      endcase
      return cc[0] ? ~v : v;
   endfunction

   assign mask  = width_mask(req.size_code);
   assign dest  = req.dest_value & mask;
   assign count = req.src_value[4:0];

   lsa_shift u_shift (
      .cmd       (req.cmd),
      .size_code (req.size_code),
      .value     (dest),
      .count     (count),
      .result    (shift_res)
   );

   // operation decode
   always_comb begin
      res       = '0;
      wb        = 1'b1;
      unsup     = 1'b0;
      flags_nxt = flags_cur;
      unique case (req.cmd) inside
         CMD_AND, CMD_TEST: begin
            res = dest & req.src_value;
            flags_nxt = '0;
            flags_nxt.zf = (res == '0);
            flags_nxt.sf = sign_bit(res, req.size_code);
            wb = (req.cmd != CMD_TEST);
         end
         CMD_OR, CMD_XOR: begin
            res = (req.cmd == CMD_OR) ? ((dest | req.src_value) & mask)
                                      : ((dest ^ req.src_value) & mask);
            flags_nxt = '0;
            flags_nxt.zf = (res == '0);
            flags_nxt.sf = sign_bit(res, req.size_code);
         end
         CMD_NOT: begin
            res = ~dest & mask;
         end
         CMD_SAR, CMD_SHL, CMD_SHR: begin
            res = shift_res;
            if (count != '0) begin
               flags_nxt.zf = (res == '0);
            end
         end
         CMD_ROL: begin
            res = shift_res;
            if (count != '0) begin
               flags_nxt.cf = res[0];
            end
         end
         CMD_SETCC: begin
            // parity conditions are not tracked
            if (req.cond_code[3:1] == COND_P) begin
               unsup = 1'b1;
               wb    = 1'b0;
            end else begin
               res = {31'd0, eval_cond(req.cond_code, flags_cur)};
            end
         end
         default: begin
            wb = 1'b0;
         end
      endcase
   end

   // pack the response
   always_comb begin
      rsp.result_value  = res;
      rsp.write_back    = wb;
      rsp.carry_flag    = flags_nxt.cf;
      rsp.overflow_flag = flags_nxt.of;
      rsp.zero_flag     = flags_nxt.zf;
      rsp.sign_flag     = flags_nxt.sf;
      rsp.unsupported   = unsup;
   end

endmodule

>>> tb/tb_x86_logic_shift_alu.sv
// ----------------------------------------------------------------------------
// tb_x86_logic_shift_alu
// Self-checking bench for the x86 logic and shift ALU. A queue of pending
// instructions (a directed corner set, then random traffic) feeds a
// valid/ready driver. A flag-tracking predictor computes the response of
// every accepted request, and the monitor compares each response with the
// oldest prediction, field by field. Both sides idle at random. There is
// also a long receiver hold-off and a few pauses that let the pipeline
// drain completely.
// ----------------------------------------------------------------------------
module tb_x86_logic_shift_alu;
   import lsa_pkg::*;

   // codes the package leaves unnamed
   localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;
   localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;
   localparam logic [1:0] SIZE_DWORD       = 2'd2;
   localparam logic [1:0] SIZE_ODD         = 2'd3;

   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_PCT     = 27;
   localparam int CALM_START   = 1500;
   localparam int CALM_END     = 2100;
   localparam int HOLD_START   = 700;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      req_type instr;
      bit      drain_first;
   } pending_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   pending_type  pending_items[$];
   rsp_type      expected_results[$];
   flags_type    kept_flags = '0;
   bit           drain_marker = 1'b0;
   bit           req_taken = 1'b0;
   int           cycle_count = 0;
   int           stall_left = 0;
   int           mismatch_count = 0;
   logic         calm_window;

   assign calm_window = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

   x86_logic_shift_alu u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // expected response of one instruction, advancing the kept flags
   function automatic rsp_type predict_instruction(input req_type instr);
      rsp_type            out;
      logic [31:0]        mask;
      logic [31:0]        dest;
      logic [31:0]        result;
      logic signed [31:0] sext;
      int unsigned        width;
      int unsigned        count;
      int unsigned        turn;
      logic               hit;
      case (instr.size_code)
         SIZE_BYTE: width = 8;
         SIZE_WORD: width = 16;
         default:   width = 32;
      endcase
      mask   = (width == 32) ? 32'hffff_ffff : ((32'd1 << width) - 32'd1);
      dest   = instr.dest_value & mask;
      count  = 32'(instr.src_value[4:0]);
      result = '0;
      out    = '0;
      out.write_back = 1'b1;
      case (instr.cmd) inside
         CMD_AND, CMD_OR, CMD_XOR, CMD_TEST: begin
            if (instr.cmd == CMD_OR)
               result = dest | instr.src_value;
            else if (instr.cmd == CMD_XOR)
               result = dest ^ instr.src_value;
            else
               result = dest & instr.src_value;
            result = result & mask;
            kept_flags    = '0;
            kept_flags.zf = (result == 32'd0);
            kept_flags.sf = result[width-1];
            out.write_back = (instr.cmd != CMD_TEST);
         end
         CMD_NOT: result = ~dest & mask;
         CMD_SAR: begin
            // sign-extend to 32 bits, then shift arithmetically
            sext   = dest | (dest[width-1] ? ~mask : 32'd0);
            sext   = sext >>> count;
            result = sext & mask;
            if (count != 0) kept_flags.zf = (result == 32'd0);
         end
         CMD_SHL: begin
            result = (dest << count) & mask;
            if (count != 0) kept_flags.zf = (result == 32'd0);
         end
         CMD_SHR: begin
            result = dest >> count;
            if (count != 0) kept_flags.zf = (result == 32'd0);
         end
         CMD_ROL: begin
            // rotate amount wraps at the width, CF follows any nonzero count
            turn = count & (width - 1);
            if (turn == 0)
               result = dest;
            else
               result = ((dest << turn) | (dest >> (width - turn))) & mask;
            if (count != 0) kept_flags.cf = result[0];
         end
         CMD_SETCC: begin
            if (instr.cond_code[3:1] == COND_P) begin
               out.unsupported = 1'b1;
               out.write_back  = 1'b0;
            end else begin
               case (instr.cond_code[3:1])
                  COND_O:  hit = kept_flags.of;
                  COND_B:  hit = kept_flags.cf;
                  COND_E:  hit = kept_flags.zf;
                  COND_BE: hit = kept_flags.cf | kept_flags.zf;
                  COND_S:  hit = kept_flags.sf;
                  COND_L:  hit = kept_flags.sf ^ kept_flags.of;
                  COND_LE: hit = kept_flags.zf | (kept_flags.sf ^ kept_flags.of);
                  default: hit = 1'b0;
               endcase
               result = {31'd0, hit ^ instr.cond_code[0]};
            end
         end
         default: out.write_back = 1'b0;
      endcase
      out.result_value  = result;
      out.carry_flag    = kept_flags.cf;
      out.overflow_flag = kept_flags.of;
      out.zero_flag     = kept_flags.zf;
      out.sign_flag     = kept_flags.sf;
      return out;
   endfunction

   task automatic queue_instruction(input logic [3:0]  cmd,
                                    input logic [1:0]  size_code,
                                    input logic [31:0] dest_value,
                                    input logic [31:0] src_value,
                                    input logic [3:0]  cond_code);
      pending_type entry;
      entry.instr       = '{cmd, size_code, dest_value, src_value, cond_code};
      entry.drain_first = drain_marker;
      drain_marker      = 1'b0;
      pending_items.push_back(entry);
   endtask

   // random instruction, biased toward corners that move the flags
   function automatic req_type random_instruction();
      req_type     item;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         item.cmd = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      else if (pick < 25)
         item.cmd = CMD_SETCC;
      else
         item.cmd = 4'($urandom_range(CMD_AND, CMD_ROL));
      if ($urandom_range(0, 99) < 8)
         item.size_code = SIZE_ODD;
      else
         item.size_code = 2'($urandom_range(SIZE_BYTE, SIZE_DWORD));
      case ($urandom_range(0, 3))
         0:       item.dest_value = 32'd0;
         1:       item.dest_value = 32'hffff_ffff;
         2:       item.dest_value = 32'd1 << $urandom_range(0, 31);
         default: item.dest_value = $urandom;
      endcase
      if (item.cmd >= CMD_SAR && item.cmd <= CMD_ROL && $urandom_range(0, 1) == 0)
         item.src_value = $urandom_range(0, 31);
      else if ($urandom_range(0, 3) == 0)
         item.src_value = ~item.dest_value;
      else
         item.src_value = $urandom;
      item.cond_code = 4'($urandom_range(0, 15));
      return item;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", field, want, got);
         mismatch_count++;
      end
   endtask

   // request driver: fresh transaction at the falling edge once the last one moved
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_items.size() != 0 &&
             (calm_window || $urandom_range(0, 99) >= IDLE_PCT) &&
             (!pending_items[0].drain_first || expected_results.size() == 0)) begin
            req_payload <= pending_items[0].instr;
            req_valid   <= 1'b1;
            void'(pending_items.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response acceptor with random idling and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (cycle_count == HOLD_START) begin
         rsp_ready  <= 1'b0;
         stall_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= calm_window || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // monitor: check responses, predict accepted requests, watch the clock budget
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         kept_flags  = '0;
         req_taken   <= 1'b0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         req_taken   <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected transaction: result_value %h", rsp_payload.result_value);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("result_value", want.result_value, rsp_payload.result_value);
               compare_field("write_back", 32'(want.write_back),
                             32'(rsp_payload.write_back));
               compare_field("carry_flag", 32'(want.carry_flag),
                             32'(rsp_payload.carry_flag));
               compare_field("overflow_flag", 32'(want.overflow_flag),
                             32'(rsp_payload.overflow_flag));
               compare_field("zero_flag", 32'(want.zero_flag),
                             32'(rsp_payload.zero_flag));
               compare_field("sign_flag", 32'(want.sign_flag),
                             32'(rsp_payload.sign_flag));
               compare_field("unsupported", 32'(want.unsupported),
                             32'(rsp_payload.unsupported));
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(predict_instruction(req_payload));
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      // logic ops at the width extremes
      queue_instruction(CMD_AND, SIZE_BYTE, 32'h0000_00ff, 32'hffff_ffff, 4'h0);
      queue_instruction(CMD_AND, SIZE_WORD, 32'hffff_ffff, 32'h0000_0000, 4'h0);
      queue_instruction(CMD_OR, SIZE_DWORD, 32'h8000_0000, 32'h0000_0001, 4'h0);
      queue_instruction(CMD_XOR, SIZE_ODD, 32'hdead_beef, 32'hdead_beef, 4'h0);
      queue_instruction(CMD_TEST, SIZE_BYTE, 32'hffff_ff80, 32'h0000_0080, 4'h0);
      queue_instruction(CMD_NOT, SIZE_DWORD, 32'h0000_0000, 32'h1234_5678, 4'h0);
      // shifts: zero count, counts past the width, sign fill
      queue_instruction(CMD_SAR, SIZE_BYTE, 32'h0000_0080, 32'd3, 4'h0);
      queue_instruction(CMD_SAR, SIZE_DWORD, 32'h8000_0000, 32'hffff_ffff, 4'h0);
      queue_instruction(CMD_SAR, SIZE_WORD, 32'h0000_8001, 32'h0000_0020, 4'h0);
      queue_instruction(CMD_SHL, SIZE_BYTE, 32'h0000_00ff, 32'd8, 4'h0);
      queue_instruction(CMD_SHL, SIZE_DWORD, 32'hffff_ffff, 32'd31, 4'h0);
      queue_instruction(CMD_SHR, SIZE_WORD, 32'hffff_ffff, 32'd15, 4'h0);
      queue_instruction(CMD_SHR, SIZE_DWORD, 32'h0000_0000, 32'hffff_ffe0, 4'h0);
      // rotates, including a count that is a multiple of the width
      queue_instruction(CMD_ROL, SIZE_BYTE, 32'h0000_0081, 32'd1, 4'h0);
      queue_instruction(CMD_ROL, SIZE_BYTE, 32'h0000_0001, 32'd8, 4'h0);
      queue_instruction(CMD_ROL, SIZE_WORD, 32'h0000_8000, 32'd17, 4'h0);
      queue_instruction(CMD_ROL, SIZE_DWORD, 32'h8000_0000, 32'd31, 4'h0);
      // setcc, parity requests and undefined commands
      queue_instruction(CMD_SETCC, SIZE_BYTE, 32'h0, 32'h0, {COND_P, 1'b0});
      queue_instruction(CMD_SETCC, SIZE_BYTE, 32'h0, 32'h0, {COND_P, 1'b1});
      queue_instruction(CMD_SETCC, SIZE_BYTE, 32'h0, 32'h0, {COND_B, 1'b0});
      queue_instruction(CMD_SETCC, SIZE_BYTE, 32'h0, 32'h0, {COND_E, 1'b1});
      queue_instruction(CMD_SETCC, SIZE_BYTE, 32'h0, 32'h0, {COND_LE, 1'b1});
      queue_instruction(CMD_FIRST_UNUSED, SIZE_WORD, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
      queue_instruction(CMD_LAST_UNUSED, SIZE_ODD, 32'hffff_ffff, 32'hffff_ffff, 4'hf);

      // random traffic, draining the pipeline at a few points
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 0 || n == 600 || n == 1200)
            drain_marker = 1'b1;
         pending_items.push_back('{random_instruction(), drain_marker});
         drain_marker = 1'b0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
